// File: sv/soq_pkg.sv
// soq_pkg: types and constants for the sequence ordered packet queue
// used by sequence_ordered_packet_queue_unit
package soq_pkg;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_POP    = 2'd2,
        OP_SETTX  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_WRITE,
        S_PEEK,
        S_OUT
    } t_state;

    localparam int NUM_BITS = 16;

    // serial compare: a < b when bit 15 of a - b is set
    function automatic logic serial_less(input logic [NUM_BITS-1:0] a,
                                         input logic [NUM_BITS-1:0] b);
        logic [NUM_BITS-1:0] d;
        d = a - b;
        return d[NUM_BITS-1];
    endfunction

endpackage

// File: sv/soq_ram.sv
// soq_ram: generic single write port ram with one registered read port
// no dependencies
module soq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: sv/sequence_ordered_packet_queue_unit.sv
// sequence_ordered_packet_queue_unit: bounded queue of packet handles kept
// with packet numbers and transmitted flags; uses soq_pkg and soq_ram
//
// input channel: i_valid/o_ready carry one operation word (append, ordered
// insert, pop head, set head transmitted flag). output channel: o_valid/
// i_ready carry one result word per operation with status and a snapshot of
// head, second and tail entries.
// entries sit in a ram in queue order from the head. a shared sequencer
// walks the ram one entry per cycle: an ordered insert scans from the head
// with one serial comparator, then shifts the tail part up one slot per
// cycle; a pop shifts every entry behind the head down one slot per cycle.
// the single ram read port sets the pace.
// the block takes one operation at a time; o_ready is low from acceptance
// until the result word is taken, and the next word can be taken in the cycle
// after that.
// reset clears the entry count and control state; ram contents need no
// clearing. when the receiver stalls the result holds and no new word is
// taken.
module sequence_ordered_packet_queue_unit
    import soq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int HANDLE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_packet_handle,
    input  logic [15:0] i_packet_number,
    input  logic        i_transmitted_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_removed_handle,
    output logic [15:0] o_removed_number,
    output logic [4:0]  o_queue_length,
    output logic        o_head_valid,
    output logic [15:0] o_head_handle,
    output logic [15:0] o_head_number,
    output logic        o_head_transmitted,
    output logic [15:0] o_tail_handle,
    output logic        o_second_valid,
    output logic [15:0] o_second_handle
);
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = HANDLE_BITS + NUM_BITS + 1;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_pos, n_pos;
    logic [1:0]    r_phase, n_phase;
    t_opcode       r_op;
    logic [HANDLE_BITS-1:0] r_handle;
    logic [NUM_BITS-1:0]    r_number;
    logic                   r_tval;
    t_status r_status, n_status;
    logic [15:0] r_rem_h, n_rem_h, r_rem_n, n_rem_n;
    logic [15:0] r_hh, n_hh, r_hn, n_hn, r_th, n_th, r_sh, n_sh;
    logic        r_ht, n_ht;
    logic        r_rd_pend, n_rd_pend;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata;
    logic [HANDLE_BITS-1:0] rd_h;
    logic [NUM_BITS-1:0]    rd_n;
    logic                   rd_t;

    soq_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign rd_h = rdata[EW-1 -: HANDLE_BITS];
    assign rd_n = rdata[NUM_BITS:1];
    assign rd_t = rdata[0];

    function automatic logic [15:0] hx(input logic [HANDLE_BITS-1:0] h);
        logic [HANDLE_BITS+15:0] w;
        w = {16'd0, h};
        return w[15:0];
    endfunction

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_rd_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_rd_pend <= n_rd_pend;
        end
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_phase  <= n_phase;
        r_status <= n_status;
        r_rem_h  <= n_rem_h;
        r_rem_n  <= n_rem_n;
        r_hh     <= n_hh;
        r_hn     <= n_hn;
        r_ht     <= n_ht;
        r_th     <= n_th;
        r_sh     <= n_sh;
        if (i_valid && o_ready) begin
            r_op     <= t_opcode'(i_opcode);
            r_handle <= i_packet_handle[HANDLE_BITS-1:0];
            r_number <= i_packet_number;
            r_tval   <= i_transmitted_value;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_phase == 2'd3) begin
                    n_state = S_SHIFT;
                end else if (r_phase == 2'd2) begin
                    n_state = S_PEEK;
                end
            end
            S_SHIFT: begin
                if (r_phase == 2'd3) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: n_state = S_PEEK;
            S_PEEK: begin
                if (r_phase == 2'd3) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and ram control
    // scan phase codes: 0 start, 1 wait read, 2 done (no shift), 3 go shift
    always_comb begin
        n_count   = r_count;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_phase   = 2'd0;
        n_status  = r_status;
        n_rem_h   = r_rem_h;
        n_rem_n   = r_rem_n;
        n_hh = r_hh; n_hn = r_hn; n_ht = r_ht; n_th = r_th; n_sh = r_sh;
        n_rd_pend = 1'b0;
        we    = 1'b0;
        waddr = '0;
        wdata = {r_handle, r_number, 1'b0};
        raddr = '0;
        unique case (r_state)
            S_IDLE: begin
                n_status = ST_DONE;
                n_rem_h  = '0;
                n_rem_n  = '0;
                n_idx    = '0;
            end
            S_SCAN: begin
                n_phase = 2'd1;
                priority if (r_phase[1]) begin
                    // done or go shift: the state moves on and no ram write happens this cycle
                    n_phase = 2'd1;
                end else if (r_phase == 2'd0) begin
                    priority if ((r_op == OP_APPEND || r_op == OP_INSERT)
                                 && r_count >= CW'(QUEUE_DEPTH)) begin
                        n_status = ST_FULL;
                        n_phase  = 2'd2;
                    end else if ((r_op == OP_POP || r_op == OP_SETTX)
                                 && r_count == '0) begin
                        n_status = ST_EMPTY;
                        n_phase  = 2'd2;
                    end else if (r_op == OP_APPEND || r_count == '0) begin
                        n_pos   = r_count;
                        n_idx   = r_count;
                        n_phase = 2'd3;
                    end else if (r_op == OP_SETTX) begin
                        raddr   = '0;
                        n_phase = 2'd1;
                    end else if (r_op == OP_POP) begin
                        raddr   = '0;
                        n_idx   = CW'(1);
                        n_phase = 2'd1;
                    end else begin
                        // tail check first
                        raddr   = AW'(r_count - CW'(1));
                        n_idx   = r_count;
                        n_phase = 2'd1;
                    end
                end else if (r_op == OP_SETTX) begin
                    we    = 1'b1;
                    waddr = '0;
                    wdata = {rd_h, rd_n, r_tval};
                    n_phase = 2'd2;
                end else if (r_op == OP_POP) begin
                    // r_idx counts shift progress; head captured first
                    if (r_idx == CW'(1) && !r_rd_pend) begin
                        n_rem_h = hx(rd_h);
                        n_rem_n = rd_n;
                    end else begin
                        we    = 1'b1;
                        waddr = AW'(r_idx - CW'(2));
                        wdata = rdata;
                    end
                    if (r_idx >= r_count) begin
                        n_count = r_count - CW'(1);
                        n_phase = 2'd2;
                    end else begin
                        raddr     = AW'(r_idx);
                        n_idx     = r_idx + CW'(1);
                        n_rd_pend = 1'b1;
                    end
                    if (r_idx == CW'(1) && !r_rd_pend) begin
                        n_idx = (r_idx >= r_count) ? r_idx : r_idx + CW'(1);
                        if (r_idx < r_count) begin
                            // first shift read issued, next cycle writes idx-2
                            n_idx = CW'(2);
                        end
                    end
                end else begin
                    // insert: r_idx == count means tail check result
                    if (r_idx == r_count && !r_rd_pend) begin
                        if (serial_less(rd_n, r_number)) begin
                            n_pos   = r_count;
                            n_idx   = r_count;
                            n_phase = 2'd3;
                        end else begin
                            raddr     = '0;
                            n_idx     = '0;
                            n_rd_pend = 1'b1;
                        end
                    end else if (serial_less(rd_n, r_number)
                                 && r_idx + CW'(1) < r_count) begin
                        raddr     = AW'(r_idx + CW'(1));
                        n_idx     = r_idx + CW'(1);
                        n_rd_pend = 1'b1;
                    end else begin
                        n_pos   = serial_less(rd_n, r_number) ?
                                  r_idx + CW'(1) : r_idx;
                        n_idx   = r_count;
                        n_phase = 2'd3;
                    end
                end
            end
            S_SHIFT: begin
                // move entries [pos, count) up by one, from the top down
                n_phase = 2'd1;
                if (r_rd_pend) begin
                    we    = 1'b1;
                    waddr = AW'(r_idx + CW'(1));
                    wdata = rdata;
                end
                if (r_idx > r_pos) begin
                    raddr     = AW'(r_idx - CW'(1));
                    n_idx     = r_idx - CW'(1);
                    n_rd_pend = 1'b1;
                end else begin
                    n_phase = 2'd3;
                end
            end
            S_WRITE: begin
                we      = 1'b1;
                waddr   = AW'(r_pos);
                n_count = r_count + CW'(1);
                n_idx   = '0;
            end
            S_PEEK: begin
                // read head, second, tail in turn; r_idx tracks which
                n_idx = r_idx + CW'(1);
                unique case (r_idx[1:0])
                    2'd0: raddr = '0;
                    2'd1: begin
                        raddr = (r_count > CW'(1)) ? AW'(1) : '0;
                        n_hh = hx(rd_h); n_hn = rd_n; n_ht = rd_t;
                    end
                    2'd2: begin
                        raddr = AW'(r_count - CW'(1));
                        n_sh  = hx(rd_h);
                    end
                    default: begin
                        n_th = hx(rd_h);
                    end
                endcase
                n_phase = (r_idx[1:0] == 2'd2) ? 2'd3 : 2'd0;
                if (r_count == '0) begin
                    n_hh = '0; n_hn = '0; n_ht = 1'b0; n_th = '0;
                end
                if (r_count < CW'(2)) begin
                    n_sh = '0;
                end
            end
            S_OUT: ;
            default: ;
        endcase
        if (r_state == S_SCAN && n_state == S_PEEK) begin
            n_idx = '0;
        end
    end

    assign o_status           = r_status;
    assign o_removed_handle   = r_rem_h;
    assign o_removed_number   = r_rem_n;
    assign o_queue_length     = 5'(r_count);
    assign o_head_valid       = (r_count != '0);
    assign o_head_handle      = r_hh;
    assign o_head_number      = r_hn;
    assign o_head_transmitted = r_ht;
    assign o_tail_handle      = r_th;
    assign o_second_valid     = (r_count > CW'(1));
    assign o_second_handle    = r_sh;
endmodule
